[rtl/pgg_pkg.sv]
package pgg_pkg;

    // Port and register widths
    localparam int POS_W    = 32;   // Q16.16 positions
    localparam int QUAT_W   = 16;   // Q2.14 quaternion parts
    localparam int GAIN_W   = 16;   // Q8.8 gains
    localparam int LIN_W    = 31;   // unsigned Q15.16 speed
    localparam int ANG_W    = 32;   // signed Q16.16 yaw rate
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int DIFF_W   = POS_W + 1;    // world offset
    localparam int COEF_W   = 19;           // rotation coefficients, Q.14
    localparam int XY_W     = 40;           // CORDIC vector
    localparam int Z_W      = 34;           // CORDIC angle, Q.30
    localparam int D_W      = 38;           // distance, Q22.16
    localparam int SPLIT_W  = 20;           // low slice for split multiplies
    localparam int ACC_W    = 64;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN   = 30;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [23:0]           INV_K_Q24   = 24'd10188014;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LINEAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGULAR = 3'd5;

    // Reset values
    localparam logic [POS_W-1:0]  STOP_RADIUS_RST  = 32'd85197;
    localparam logic [GAIN_W-1:0] GAIN_LINEAR_RST  = 16'd26;
    localparam logic [GAIN_W-1:0] GAIN_ANGULAR_RST = 16'd282;

    // atan(2^-i) in Q.30
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd843314856;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                5'd24: v = 34'sd64;
                5'd25: v = 34'sd32;
                5'd26: v = 34'sd16;
                5'd27: v = 34'sd8;
                5'd28: v = 34'sd4;
                5'd29: v = 34'sd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/pgg_mul.sv]
module pgg_mul (
    input  logic                                i_clk,
    input  logic signed [pgg_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [pgg_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [pgg_pkg::PROD_W-1:0]   o_prod
);
    import pgg_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Register the product; the sequencer reads it in the cycle after issue.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/planar_go_to_goal_controller_core.sv]
// Channel   | valid       | stall        | payload
// ----------+-------------+--------------+------------------------------------------------
// pose in   | i_in_valid  | o_in_stall   | i_pose_present, i_robot_x/y, i_robot_qz/qw
// command   | o_out_valid | i_out_stall  | o_linear_velocity, o_angular_velocity
// config    | i_cfg_wr_en | (none)       | i_cfg_index, i_cfg_wdata
//
// An item with a target set runs through the sequencer states from its transfer to the
// result load, paced by the one shared multiplier and the
// one-step-per-cycle CORDIC loop; the next transfer can come in the cycle after the load.
// A zero offset skips the loop. Without a target an item finishes in its transfer
// cycle and gives no result.
// Reset is synchronous, active low; it clears the sequencer, the output valid, the
// stored pose and restores the register defaults.
// o_in_stall is high while an item is at work, and while a finished result waits
// for a stalled output register to empty.
module planar_go_to_goal_controller_core #(
    parameter int CORDIC_STEPS = pgg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_cfg_wr_en,
    input  logic [pgg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pgg_pkg::CFG_DATA_W-1:0]          i_cfg_wdata,

    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_pose_present,
    input  logic signed [pgg_pkg::POS_W-1:0]        i_robot_x,
    input  logic signed [pgg_pkg::POS_W-1:0]        i_robot_y,
    input  logic signed [pgg_pkg::QUAT_W-1:0]       i_robot_qz,
    input  logic signed [pgg_pkg::QUAT_W-1:0]       i_robot_qw,

    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [pgg_pkg::LIN_W-1:0]               o_linear_velocity,
    output logic signed [pgg_pkg::ANG_W-1:0]        o_angular_velocity
);
    import pgg_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    // Sequencer states
    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE = 5'd0;
    localparam logic [ST_W-1:0] S_QZ   = 5'd1;   // issue qz*qz
    localparam logic [ST_W-1:0] S_QW   = 5'd2;   // issue qw*qz, form c
    localparam logic [ST_W-1:0] S_CDX  = 5'd3;   // issue c*dx, form s
    localparam logic [ST_W-1:0] S_SDY  = 5'd4;   // issue s*dy
    localparam logic [ST_W-1:0] S_CDY  = 5'd5;   // issue c*dy, form x
    localparam logic [ST_W-1:0] S_SDX  = 5'd6;   // issue s*dx
    localparam logic [ST_W-1:0] S_YV   = 5'd7;   // form y
    localparam logic [ST_W-1:0] S_PRE  = 5'd8;   // quadrant fold
    localparam logic [ST_W-1:0] S_ROT  = 5'd9;   // CORDIC micro-rotations
    localparam logic [ST_W-1:0] S_NLO  = 5'd10;  // norm, low slice
    localparam logic [ST_W-1:0] S_NHI  = 5'd11;  // norm, high slice
    localparam logic [ST_W-1:0] S_NACC = 5'd12;
    localparam logic [ST_W-1:0] S_DIST = 5'd13;  // round, apply stop radius
    localparam logic [ST_W-1:0] S_LLO  = 5'd14;  // linear gain, low slice
    localparam logic [ST_W-1:0] S_LHI  = 5'd15;  // linear gain, high slice
    localparam logic [ST_W-1:0] S_LACC = 5'd16;  // also issue angular gain
    localparam logic [ST_W-1:0] S_ANG  = 5'd17;  // round, load output

    // Configuration
    logic signed [POS_W-1:0]  r_target_x;
    logic signed [POS_W-1:0]  r_target_y;
    logic                     r_target_set;
    logic [POS_W-1:0]         r_stop_radius;
    logic [GAIN_W-1:0]        r_gain_linear;
    logic [GAIN_W-1:0]        r_gain_angular;

    // Stored pose
    logic signed [POS_W-1:0]  r_pose_x;
    logic signed [POS_W-1:0]  r_pose_y;
    logic signed [QUAT_W-1:0] r_pose_qz;
    logic signed [QUAT_W-1:0] r_pose_qw;

    // Sequencer and datapath
    logic [ST_W-1:0]          r_state;
    logic [STEP_W-1:0]        r_i;
    logic signed [COEF_W-1:0] r_c14;
    logic signed [COEF_W-1:0] r_s14;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic signed [Z_W-1:0]    r_z;
    logic [D_W-1:0]           r_d;

    // Output register
    logic                     r_out_valid;
    logic [LIN_W-1:0]         r_lin;
    logic signed [ANG_W-1:0]  r_ang;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      in_xfer;
    logic                      out_free;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [MUL_A_W-1:0]        c_sum;
    logic [MUL_A_W-1:0]        s_sum;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   x_sum;
    logic signed [ACC_W-1:0]   y_sum;
    logic signed [ACC_W-1:0]   acc_hi;
    logic [ACC_W-1:0]          d_sum;
    logic [D_W-1:0]            d_val;
    logic [ACC_W-1:0]          lin_sum;
    logic signed [PROD_W-1:0]  ang_sum;
    logic signed [XY_W-1:0]    x_pos;
    logic signed [XY_W-1:0]    xs;
    logic signed [XY_W-1:0]    ys;
    logic signed [Z_W-1:0]     atan_step;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign dx = DIFF_W'(r_target_x) - DIFF_W'(r_pose_x);
    assign dy = DIFF_W'(r_target_y) - DIFF_W'(r_pose_y);

    // c = 1 - 2 qz^2 and s = 2 qw qz, Q.28, rounded half up to Q.14
    assign c_sum = MUL_A_W'(34'd268443648) - {prod[MUL_A_W-2:0], 1'b0};
    assign s_sum = {prod[MUL_A_W-2:0], 1'b0} + MUL_A_W'(34'd8192);

    assign prod_ext = ACC_W'(prod);
    assign x_sum    = r_acc + prod_ext;
    assign y_sum    = r_acc - prod_ext;
    assign acc_hi   = r_acc + (prod_ext <<< SPLIT_W);
    assign d_sum    = r_acc + ACC_W'(64'd8388608);
    assign d_val    = d_sum[D_W+23:24];
    assign lin_sum  = r_acc + ACC_W'(64'd128);
    assign ang_sum  = prod + PROD_W'(59'sd2097152);

    // Negative CORDIC x after the loop counts as zero distance
    assign x_pos     = r_x[XY_W-1] ? '0 : r_x;
    assign xs        = r_x >>> r_i;
    assign ys        = r_y >>> r_i;
    assign atan_step = atan_q30(ATAN_IDX_W'(r_i));

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_QZ: begin
                mul_a = MUL_A_W'(r_pose_qz);
                mul_b = MUL_B_W'(r_pose_qz);
            end
            S_QW: begin
                mul_a = MUL_A_W'(r_pose_qw);
                mul_b = MUL_B_W'(r_pose_qz);
            end
            S_CDX: begin
                mul_a = MUL_A_W'(dx);
                mul_b = MUL_B_W'(r_c14);
            end
            S_SDY: begin
                mul_a = MUL_A_W'(dy);
                mul_b = MUL_B_W'(r_s14);
            end
            S_CDY: begin
                mul_a = MUL_A_W'(dy);
                mul_b = MUL_B_W'(r_c14);
            end
            S_SDX: begin
                mul_a = MUL_A_W'(dx);
                mul_b = MUL_B_W'(r_s14);
            end
            S_NLO: begin
                mul_a = {{(MUL_A_W-SPLIT_W){1'b0}}, x_pos[SPLIT_W-1:0]};
                mul_b = {{(MUL_B_W-24){1'b0}}, INV_K_Q24};
            end
            S_NHI: begin
                mul_a = {{(MUL_A_W-(XY_W-SPLIT_W)){1'b0}}, x_pos[XY_W-1:SPLIT_W]};
                mul_b = {{(MUL_B_W-24){1'b0}}, INV_K_Q24};
            end
            S_LLO: begin
                mul_a = {{(MUL_A_W-SPLIT_W){1'b0}}, r_d[SPLIT_W-1:0]};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, r_gain_linear};
            end
            S_LHI: begin
                mul_a = {{(MUL_A_W-(D_W-SPLIT_W)){1'b0}}, r_d[D_W-1:SPLIT_W]};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, r_gain_linear};
            end
            S_LACC, S_ANG: begin
                // hold the operands in S_ANG so the product stays put under stall
                mul_a = r_z;
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, r_gain_angular};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pgg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x     <= '0;
            r_target_y     <= '0;
            r_target_set   <= 1'b0;
            r_stop_radius  <= STOP_RADIUS_RST;
            r_gain_linear  <= GAIN_LINEAR_RST;
            r_gain_angular <= GAIN_ANGULAR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TARGET_X:     r_target_x     <= i_cfg_wdata;
                REG_TARGET_Y:     r_target_y     <= i_cfg_wdata;
                REG_TARGET_SET:   r_target_set   <= i_cfg_wdata[0];
                REG_STOP_RADIUS:  r_stop_radius  <= i_cfg_wdata;
                REG_GAIN_LINEAR:  r_gain_linear  <= i_cfg_wdata[GAIN_W-1:0];
                REG_GAIN_ANGULAR: r_gain_angular <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pose latch: take the pose only when the transfer carries one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_pose_qz <= '0;
            r_pose_qw <= '0;
        end else if (in_xfer && i_pose_present) begin
            r_pose_x  <= i_robot_x;
            r_pose_y  <= i_robot_y;
            r_pose_qz <= i_robot_qz;
            r_pose_qw <= i_robot_qw;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_xfer && r_target_set) r_state <= S_QZ;
                S_QZ:   r_state <= S_QW;
                S_QW:   r_state <= S_CDX;
                S_CDX:  r_state <= S_SDY;
                S_SDY:  r_state <= S_CDY;
                S_CDY:  r_state <= S_SDX;
                S_SDX:  r_state <= S_YV;
                S_YV:   r_state <= S_PRE;
                S_PRE: begin
                    // a zero offset skips the loop: bearing and distance are zero
                    if (r_x == '0 && r_y == '0) r_state <= S_NLO;
                    else                        r_state <= S_ROT;
                end
                S_ROT:  if (r_i == LAST_STEP) r_state <= S_NLO;
                S_NLO:  r_state <= S_NHI;
                S_NHI:  r_state <= S_NACC;
                S_NACC: r_state <= S_DIST;
                S_DIST: r_state <= S_LLO;
                S_LLO:  r_state <= S_LHI;
                S_LHI:  r_state <= S_LACC;
                S_LACC: r_state <= S_ANG;
                S_ANG:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_QW:  r_c14 <= c_sum[32:14];
            S_CDX: r_s14 <= s_sum[32:14];
            S_SDY: r_acc <= prod_ext;
            S_CDY: r_x   <= x_sum[XY_W+13:14];
            S_SDX: r_acc <= prod_ext;
            S_YV:  r_y   <= y_sum[XY_W+13:14];
            S_PRE: begin
                r_i <= '0;
                if (r_x == '0 && r_y == '0) begin
                    r_z <= '0;
                end else if (r_x[XY_W-1]) begin
                    // fold the left half plane by a quarter turn
                    if (!r_y[XY_W-1]) begin
                        r_x <= r_y;
                        r_y <= -r_x;
                        r_z <= HALF_PI_Q30;
                    end else begin
                        r_x <= -r_y;
                        r_y <= r_x;
                        r_z <= -HALF_PI_Q30;
                    end
                end else begin
                    r_z <= '0;
                end
            end
            S_ROT: begin
                r_i <= r_i + 1'b1;
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_step;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_step;
                end
            end
            S_NHI:  r_acc <= prod_ext;
            S_NACC: r_acc <= acc_hi;
            S_DIST: r_d   <= (d_val <= D_W'(r_stop_radius)) ? '0 : d_val;
            S_LHI:  r_acc <= prod_ext;
            S_LACC: r_acc <= acc_hi;
            default: ;
        endcase
    end

    // Output register: load from S_ANG when free, drop valid on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_ANG && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ANG && out_free) begin
            // saturate the speed; the yaw rate always fits its 32 bits
            r_lin <= (lin_sum[ACC_W-1:LIN_W+8] != '0) ? '1 : lin_sum[LIN_W+7:8];
            r_ang <= ang_sum[ANG_W+21:22];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_linear_velocity  = r_lin;
    assign o_angular_velocity = r_ang;

endmodule

[rtl/pgg_checker.sv]
module pgg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [pgg_pkg::LIN_W-1:0]        o_linear_velocity,
    input logic [pgg_pkg::ANG_W-1:0]        o_angular_velocity
);
    import pgg_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_linear_velocity) && $stable(o_angular_velocity))
        else $error("result payload changed under stall");

    // A result only appears at the end of a busy period
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // Leaving the busy period always leaves a result behind
    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("work finished without a result");

    // Work starts only from an input transfer
    a_busy_from_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("became busy without an input transfer");

endmodule

bind planar_go_to_goal_controller_core pgg_checker u_pgg_checker (.*);

[dv/planar_go_to_goal_controller_core_tb.sv]
module planar_go_to_goal_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgg_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int STEPS           = CORDIC_STEPS_DEF;
    // Loop count of the angle solver: the arctangent table has 30 entries
    localparam int SOLVE_STEPS     = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    // Covers one whole item; leave some margin on top
    localparam int SETTLE_CYCLES   = 17 + STEPS + 10;
    localparam int TAIL_CYCLES     = 2 * (17 + STEPS);
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 75;

    // Register indexes past the last defined register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Angle solver constants, all angles in Q.30 radians
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint unsigned INV_GAIN_Q24 = 64'd10188014;
    localparam longint ATAN_Q30 [0:29] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
        64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
        64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128,       64'sd64,
        64'sd32,        64'sd16,        64'sd8,         64'sd4,         64'sd2
    };
    localparam longint ANG_MAX = 64'sd2147483647;
    localparam longint ANG_MIN = -ANG_MAX - 1;
    localparam longint unsigned LIN_MAX = 64'h7FFF_FFFF;

    // Corner values for positions and quaternion parts
    localparam logic [POS_W-1:0] POS_CORNER [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };
    localparam logic [QUAT_W-1:0] QUAT_CORNER [6] = '{
        16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0000, 16'hFFFF
    };

    typedef struct packed {
        logic                     present;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
    } pose_t;

    typedef struct packed {
        logic [LIN_W-1:0]        lin;
        logic signed [ANG_W-1:0] ang;
    } command_t;

    // Tracks the controller's registers and stored pose, predicts the velocity
    // command of every accepted pose update with a target set and checks the commands in order.
    class command_scoreboard;
        logic signed [POS_W-1:0]  tgt_x;
        logic signed [POS_W-1:0]  tgt_y;
        logic                     tgt_on;
        logic [POS_W-1:0]         stop_r;
        logic [GAIN_W-1:0]        k_lin;
        logic [GAIN_W-1:0]        k_ang;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [QUAT_W-1:0] pqz;
        logic signed [QUAT_W-1:0] pqw;
        command_t                 expected_cmds[$];
        int                       errors;

        function new();
            tgt_x  = '0;
            tgt_y  = '0;
            tgt_on = 1'b0;
            stop_r = 32'd85197;
            k_lin  = 16'd26;
            k_ang  = 16'd282;
            px     = '0;
            py     = '0;
            pqz    = '0;
            pqw    = '0;
            errors = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_X:     tgt_x  = data;
                REG_TARGET_Y:     tgt_y  = data;
                REG_TARGET_SET:   tgt_on = data[0];
                REG_STOP_RADIUS:  stop_r = data;
                REG_GAIN_LINEAR:  k_lin  = data[GAIN_W-1:0];
                REG_GAIN_ANGULAR: k_ang  = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function command_t predict_command();
            longint c28, s28, c14, s14, dx, dy, x, y, z, t, xs, ys, ang;
            longint unsigned d, lin;
            command_t cmd;
            // Planar rotation from the yaw quaternion, rounded to Q.14
            c28 = (64'sd1 <<< 28) - 2 * longint'(pqz) * longint'(pqz);
            s28 = 2 * longint'(pqw) * longint'(pqz);
            c14 = (c28 + (64'sd1 <<< 13)) >>> 14;
            s14 = (s28 + (64'sd1 <<< 13)) >>> 14;
            // World offset to the target, turned into the robot frame (transpose)
            dx = longint'(tgt_x) - longint'(px);
            dy = longint'(tgt_y) - longint'(py);
            x = (c14 * dx + s14 * dy) >>> 14;
            y = (c14 * dy - s14 * dx) >>> 14;
            z = 0;
            d = 0;
            if (x != 0 || y != 0) begin
                // Fold the left half plane onto the right one first
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin
                        x = y;
                        y = -t;
                        z = QUARTER_TURN_Q30;
                    end else begin
                        x = -y;
                        y = t;
                        z = -QUARTER_TURN_Q30;
                    end
                end
                for (int i = 0; i < SOLVE_STEPS; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_Q30[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_Q30[i];
                    end
                end
                if (x < 0)
                    x = 0;
                d = ($unsigned(x) * INV_GAIN_Q24 + (64'd1 << 23)) >> 24;
            end
            if (d <= 64'(stop_r))
                d = 0;
            lin = (64'(k_lin) * d + 64'd128) >> 8;
            if (lin > LIN_MAX)
                lin = LIN_MAX;
            ang = (longint'(k_ang) * z + (64'sd1 <<< 21)) >>> 22;
            if (ang > ANG_MAX)
                ang = ANG_MAX;
            if (ang < ANG_MIN)
                ang = ANG_MIN;
            cmd.lin = lin[LIN_W-1:0];
            cmd.ang = ang[ANG_W-1:0];
            return cmd;
        endfunction

        // Latch the pose when present; with a target set, one command follows
        function void take_pose(input pose_t p);
            if (p.present) begin
                px  = p.x;
                py  = p.y;
                pqz = p.qz;
                pqw = p.qw;
            end
            if (tgt_on)
                expected_cmds.push_back(predict_command());
        endfunction

        function void check_command(input logic [LIN_W-1:0] lin,
                                    input logic signed [ANG_W-1:0] ang);
            command_t want;
            if (expected_cmds.size() == 0) begin
                $display("%0t: command with none pending: linear %0d angular %0d",
                         $time, lin, ang);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            if (want.lin !== lin) begin
                $display("%0t: linear_velocity expected %0d actual %0d",
                         $time, want.lin, lin);
                errors++;
            end
            if (want.ang !== ang) begin
                $display("%0t: angular_velocity expected %0d actual %0d",
                         $time, want.ang, ang);
                errors++;
            end
        endfunction
    endclass

    // Block ports; every input starts at a known value
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_pose_present = 1'b0;
    logic signed [POS_W-1:0]  i_robot_x = '0;
    logic signed [POS_W-1:0]  i_robot_y = '0;
    logic signed [QUAT_W-1:0] i_robot_qz = '0;
    logic signed [QUAT_W-1:0] i_robot_qw = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [LIN_W-1:0]         o_linear_velocity;
    logic signed [ANG_W-1:0]  o_angular_velocity;

    command_scoreboard sb;
    pose_t             plan[$];
    // Ask the command side for one long hold-off
    bit                hold_off_req = 1'b0;

    planar_go_to_goal_controller_core #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pose_present    (i_pose_present),
        .i_robot_x         (i_robot_x),
        .i_robot_y         (i_robot_y),
        .i_robot_qz        (i_robot_qz),
        .i_robot_qw        (i_robot_qw),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_linear_velocity (o_linear_velocity),
        .o_angular_velocity(o_angular_velocity)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Gap length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic pose_t mk_pose(input logic present,
                                      input logic [POS_W-1:0] x,
                                      input logic [POS_W-1:0] y,
                                      input logic [QUAT_W-1:0] qz,
                                      input logic [QUAT_W-1:0] qw);
        pose_t p;
        p.present = present;
        p.x       = x;
        p.y       = y;
        p.qz      = qz;
        p.qw      = qw;
        return p;
    endfunction

    // Random pose: mostly a unit yaw quaternion near the target, the rest
    // noise over the full field ranges and corner values
    function automatic pose_t rand_pose();
        pose_t p;
        int    r;
        int    qw_i;
        int    qz_i;
        r = $urandom_range(0, 99);
        p.present = ($urandom_range(0, 99) < 88);
        qw_i = int'($urandom_range(0, 32768)) - 16384;
        qz_i = $rtoi($sqrt(268435456.0 - real'(qw_i * qw_i)));
        if ($urandom_range(0, 1) == 1)
            qz_i = -qz_i;
        p.qw = 16'(qw_i);
        p.qz = 16'(qz_i);
        if (r < 60) begin
            // within 20 m of the target
            p.x = sb.tgt_x + (int'($urandom_range(0, 2621440)) - 1310720);
            p.y = sb.tgt_y + (int'($urandom_range(0, 2621440)) - 1310720);
        end else if (r < 72) begin
            // on the target or inside a typical stop radius
            if ($urandom_range(0, 2) == 0) begin
                p.x = sb.tgt_x;
                p.y = sb.tgt_y;
            end else begin
                p.x = sb.tgt_x + (int'($urandom_range(0, 196608)) - 98304);
                p.y = sb.tgt_y + (int'($urandom_range(0, 196608)) - 98304);
            end
        end else if (r < 87) begin
            p.x  = $urandom();
            p.y  = $urandom();
            p.qz = 16'($urandom());
            p.qw = 16'($urandom());
        end else begin
            p.x  = POS_CORNER[$urandom_range(0, 3)];
            p.y  = POS_CORNER[$urandom_range(0, 3)];
            p.qz = QUAT_CORNER[$urandom_range(0, 5)];
            p.qw = QUAT_CORNER[$urandom_range(0, 5)];
        end
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_target();
        if ($urandom_range(0, 99) < 70)
            return int'($urandom_range(0, 6553600)) - 3276800;   // within 50 m
        return $urandom();
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_stop_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 327680);
        if (r < 80)
            return '0;
        if (r < 90)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Upper data bits above a gain are don't-care and get random content at times
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 1023);
        if (r < 65)
            return '0;
        if (r < 80)
            return 32'h0000_FFFF;
        return $urandom();
    endfunction

    // Drive one register write; the block takes it at the next rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one pose update and hold it until the transfer
    task automatic offer_pose(input pose_t p);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_pose_present <= p.present;
        i_robot_x      <= p.x;
        i_robot_y      <= p.y;
        i_robot_qz     <= p.qz;
        i_robot_qw     <= p.qw;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_pose(p);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait for every predicted command
    task automatic drain_commands();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Drain, then let an item that gives no command finish before a register write
    task automatic settle();
        drain_commands();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic play_plan();
        foreach (plan[k]) begin
            offer_pose(plan[k]);
            idle_sender(idle_len());
        end
        plan.delete();
    endtask

    // Command side: random stall pattern with occasional open stretches,
    // plus one long hold-off on request so the block backs up into its input
    initial begin : command_receiver
        int open_left;
        int stall_left;
        open_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                open_left    = 0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (open_left == 0 && stall_left == 0) begin
                open_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(0, 12);
                stall_left = idle_len();
            end
            if (open_left > 0) begin
                i_out_stall <= 1'b0;
                open_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check every command transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_command(o_linear_velocity, o_angular_velocity);
    end

    // Give up once no transfer has happened on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("planar_go_to_goal_controller_core verification failed");
        $finish;
    end

    initial begin : stimulus
        bit burst;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // No target after reset: the pose is latched, no command comes out
        plan.push_back(mk_pose(1'b1, 32'sd65536, 32'sd65536, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b0, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 16'h1234, 16'hEDCB));
        play_plan();

        // Target at (3, -2) m with the reset stop radius and gains
        settle();
        write_reg(REG_TARGET_X, 32'sd196608);
        write_reg(REG_TARGET_Y, -32'sd131072);
        write_reg(REG_TARGET_SET, 32'd1);
        // stored pose from the no-target phase
        plan.push_back(mk_pose(1'b0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF));
        // zero offset
        plan.push_back(mk_pose(1'b1, 32'sd196608, -32'sd131072, 16'sd0, 16'sd16384));
        // straight ahead, straight behind, behind and to the right
        plan.push_back(mk_pose(1'b1, 32'sd0, -32'sd131072, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b1, 32'sd393216, -32'sd131072, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b1, 32'sd393216, -32'sd65536, 16'sd0, 16'sd16384));
        // half a metre short: inside the stop radius
        plan.push_back(mk_pose(1'b1, 32'sd163840, -32'sd131072, 16'sd0, 16'sd16384));
        // yaw of a quarter turn and of half a turn either way
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, 16'sd11585, 16'sd11585));
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, 16'sd16384, 16'sd0));
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, -16'sd16384, 16'sd0));
        // quaternion parts far from unit length, used without normalizing
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, 16'h8000, 16'h8000));
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, 16'h7FFF, 16'h7FFF));
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, 16'h0000, 16'h0000));
        // position corners
        plan.push_back(mk_pose(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF));
        play_plan();

        // Far target, no stop radius, full gains: the speed saturates
        settle();
        write_reg(REG_TARGET_X, 32'h7FFF_FFFF);
        write_reg(REG_TARGET_Y, 32'h8000_0000);
        write_reg(REG_STOP_RADIUS, 32'd0);
        write_reg(REG_GAIN_LINEAR, 32'h0000_FFFF);
        write_reg(REG_GAIN_ANGULAR, 32'h0000_FFFF);
        plan.push_back(mk_pose(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd16384, 16'sd0));
        plan.push_back(mk_pose(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000));
        plan.push_back(mk_pose(1'b0, 32'h0, 32'h0, 16'h0, 16'h0));
        plan.push_back(mk_pose(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0, 16'sd16384));
        play_plan();

        // Widest stop radius, zero gains; spare register indexes change nothing
        settle();
        write_reg(REG_TARGET_X, -32'sd65536);
        write_reg(REG_TARGET_Y, 32'sd65536);
        write_reg(REG_STOP_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_LINEAR, 32'd0);
        write_reg(REG_GAIN_ANGULAR, 32'd0);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        plan.push_back(mk_pose(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0, 16'sd16384));
        plan.push_back(mk_pose(1'b1, 32'sd0, 32'sd0, -16'sd11585, 16'sd11585));
        play_plan();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            write_reg(REG_TARGET_X, pick_target());
            write_reg(REG_TARGET_Y, pick_target());
            // one phase without a target; the rest with random upper data bits
            write_reg(REG_TARGET_SET, (ph == 5) ? 32'd0 : ($urandom() | 32'd1));
            write_reg(REG_STOP_RADIUS, pick_stop_radius());
            write_reg(REG_GAIN_LINEAR, pick_gain());
            write_reg(REG_GAIN_ANGULAR, pick_gain());
            burst = (ph == 1 || ph == 6);
            if (ph == 2)
                hold_off_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_pose(rand_pose());
                // once: pause the pose side until every command is out
                if (ph == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_commands();
                idle_sender(burst ? 0 : idle_len());
            end
        end

        drain_commands();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("planar_go_to_goal_controller_core verification clean");
        else
            $display("planar_go_to_goal_controller_core verification failed");
        $finish;
    end

endmodule
